FILE: hw/rtl/dotq_pkg.sv
// Shared constants and types for the deadline-ordered timer queue.
package dotq_pkg;

    localparam int TIMER_SLOTS_DEF = 16;
    localparam int TIME_BITS_DEF   = 48;
    localparam int MAX_RESULTS     = 16;
    localparam int CNT_BITS        = $clog2(MAX_RESULTS);
    localparam int WIDE_BITS       = 65;
    localparam int HANDLE_BITS     = 4;
    localparam int NOW_BITS        = 48;
    localparam int DELAY_BITS      = 32;
    localparam int WAIT_BITS       = 32;

    typedef enum logic [1:0] {
        FUNC_ADD  = 2'd0,
        FUNC_DEL  = 2'd1,
        FUNC_TICK = 2'd2,
        FUNC_NONE = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    typedef struct packed {
        logic ins_en;
        logic rem_en;
    } cell_ctl_t;

endpackage

FILE: hw/rtl/dotq_cell.sv
// One cell of the sorted timer chain: holds one entry and shifts with its neighbours.
module dotq_cell
    import dotq_pkg::*;
#(
    parameter int TW  = TIME_BITS_DEF,
    parameter int HW  = 4,
    parameter int HCW = 4
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  cell_ctl_t     ctl,
    input  logic [TW-1:0] new_dl,
    input  logic [TW-1:0] new_at,
    input  logic [HW-1:0] new_h,
    input  logic [HCW-1:0] key,
    input  logic          left_valid,
    input  logic [TW-1:0] left_dl,
    input  logic [TW-1:0] left_at,
    input  logic [HW-1:0] left_h,
    input  logic          move_in,
    input  logic          rem_in,
    input  logic          right_valid,
    input  logic [TW-1:0] right_dl,
    input  logic [TW-1:0] right_at,
    input  logic [HW-1:0] right_h,
    output logic          valid,
    output logic [TW-1:0] dl,
    output logic [TW-1:0] at,
    output logic [HW-1:0] h,
    output logic          move_out,
    output logic          rem_out,
    output logic          valid_next,
    output logic [TW-1:0] dl_next
);

    logic          valid_reg;
    logic [TW-1:0] dl_reg;
    logic [TW-1:0] at_reg;
    logic [HW-1:0] h_reg;
    logic [TW-1:0] at_next;
    logic [HW-1:0] h_next;
    logic          match;

    assign move_out = ctl.ins_en && !(valid_reg && (dl_reg <= new_dl));
    assign match    = ctl.rem_en && valid_reg && (HCW'(h_reg) == key);
    assign rem_out  = rem_in || match;

    always_comb
    begin
        priority if (move_out && move_in)
        begin
            valid_next = left_valid;
            dl_next    = left_dl;
            at_next    = left_at;
            h_next     = left_h;
        end
        else if (move_out)
        begin
            valid_next = 1'b1;
            dl_next    = new_dl;
            at_next    = new_at;
            h_next     = new_h;
        end
        else if (rem_out)
        begin
            valid_next = right_valid;
            dl_next    = right_dl;
            at_next    = right_at;
            h_next     = right_h;
        end
        else
        begin
            valid_next = valid_reg;
            dl_next    = dl_reg;
            at_next    = at_reg;
            h_next     = h_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dl_reg <= dl_next;
        at_reg <= at_next;
        h_reg  <= h_next;
    end

    assign valid = valid_reg;
    assign dl    = dl_reg;
    assign at    = at_reg;
    assign h     = h_reg;

endmodule

FILE: hw/rtl/deadline_ordered_timer_queue.sv
// Top level of the deadline-ordered timer queue: input stage, cell chain, control, result register.
// Accepted inputs are registered; each result is registered in the execute state once output is free.
// Add, delete and other items each pass once through execute; a tick fires at most 16 due timers,
// one per cycle from the chain front while output is not stalled; input is taken only in idle.
// Output stalls hold the chain; the result register lets a new item in while a last result waits.
// Reset: asynchronous, clears all cell valid bits and the handle map; no clearing pass.
module deadline_ordered_timer_queue
    import dotq_pkg::*;
#(
    parameter int TIMER_SLOTS = TIMER_SLOTS_DEF,
    parameter int TIME_BITS   = TIME_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [1:0]             func,
    input  logic [NOW_BITS-1:0]    now_time,
    input  logic [DELAY_BITS-1:0]  delay,
    input  logic [HANDLE_BITS-1:0] handle_in,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [HANDLE_BITS-1:0] handle_out,
    output logic                   accepted,
    output logic                   fired,
    output logic [NOW_BITS-1:0]    fired_add_time,
    output logic [WAIT_BITS-1:0]   wait_time,
    output logic                   queue_empty,
    output logic                   last
);

    localparam int TW  = TIME_BITS;
    localparam int HW  = $clog2(TIMER_SLOTS);
    localparam int HCW = (HW > HANDLE_BITS) ? HW : HANDLE_BITS;

    state_t                 state_reg, state_next;
    func_t                  func_reg;
    logic [TW-1:0]          now_reg;
    logic [TW-1:0]          dl_reg;
    logic [HANDLE_BITS-1:0] hin_reg;
    logic [CNT_BITS-1:0]    cnt_reg, cnt_next;
    logic [TIMER_SLOTS-1:0] busy_reg, busy_next;

    logic                   out_valid_reg;
    logic [HANDLE_BITS-1:0] handle_out_reg;
    logic                   accepted_reg;
    logic                   fired_reg;
    logic [NOW_BITS-1:0]    fired_add_time_reg;
    logic [WAIT_BITS-1:0]   wait_time_reg;
    logic                   queue_empty_reg;
    logic                   last_reg;

    logic [TW-1:0]          now_t;
    logic [WIDE_BITS-1:0]   sum_w;
    logic [TW-1:0]          dl_in;
    logic                   in_beat;
    logic                   out_free;
    logic                   load;

    cell_ctl_t              ctl;
    logic                   pop_en;
    logic [HCW-1:0]         key;
    logic [HW-1:0]          free_h;
    logic                   full;
    logic                   found;
    logic                   due0;
    logic                   due1;
    logic                   set_en;
    logic                   clr_en;
    logic [HCW-1:0]         clr_key;

    logic [HANDLE_BITS-1:0] r_handle;
    logic                   r_acc;
    logic                   r_fired;
    logic [TW-1:0]          r_at;
    logic                   r_last;
    logic [TW-1:0]          diff;
    logic [WIDE_BITS-1:0]   diff_w;
    logic [WAIT_BITS-1:0]   wait_calc;

    logic                   c_valid [TIMER_SLOTS];
    logic [TW-1:0]          c_dl    [TIMER_SLOTS];
    logic [TW-1:0]          c_at    [TIMER_SLOTS];
    logic [HW-1:0]          c_h     [TIMER_SLOTS];
    logic                   c_vnext [TIMER_SLOTS];
    logic [TW-1:0]          c_dnext [TIMER_SLOTS];
    logic                   c_move  [TIMER_SLOTS+1];
    logic                   c_rem   [TIMER_SLOTS+1];

    // Input stage: mask time and form the saturated deadline
    assign now_t   = TW'(now_time);
    assign sum_w   = WIDE_BITS'(now_t) + WIDE_BITS'(delay);
    assign dl_in   = (sum_w[WIDE_BITS-1:TW] != '0) ? '1 : sum_w[TW-1:0];
    assign in_ready = (state_reg == ST_IDLE);
    assign in_beat  = in_valid && in_ready;

    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            func_reg <= func_t'(func);
            now_reg  <= now_t;
            dl_reg   <= dl_in;
            hin_reg  <= handle_in;
        end
    end

    // Cell chain
    assign c_move[0] = 1'b0;
    assign c_rem[0]  = pop_en;
    assign key       = HCW'(hin_reg);

    for (genvar i = 0; i < TIMER_SLOTS; i++)
    begin : g_cell
        logic          lv, rv;
        logic [TW-1:0] ld, la, rd, ra;
        logic [HW-1:0] lh, rh;

        if (i == 0)
        begin : g_first
            assign lv = 1'b0;
            assign ld = '0;
            assign la = '0;
            assign lh = '0;
        end
        else
        begin : g_mid
            assign lv = c_valid[i-1];
            assign ld = c_dl[i-1];
            assign la = c_at[i-1];
            assign lh = c_h[i-1];
        end

        if (i == TIMER_SLOTS - 1)
        begin : g_tail
            assign rv = 1'b0;
            assign rd = '0;
            assign ra = '0;
            assign rh = '0;
        end
        else
        begin : g_body
            assign rv = c_valid[i+1];
            assign rd = c_dl[i+1];
            assign ra = c_at[i+1];
            assign rh = c_h[i+1];
        end

        dotq_cell #(
            .TW  (TW),
            .HW  (HW),
            .HCW (HCW)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctl         (ctl),
            .new_dl      (dl_reg),
            .new_at      (now_reg),
            .new_h       (free_h),
            .key         (key),
            .left_valid  (lv),
            .left_dl     (ld),
            .left_at     (la),
            .left_h      (lh),
            .move_in     (c_move[i]),
            .rem_in      (c_rem[i]),
            .right_valid (rv),
            .right_dl    (rd),
            .right_at    (ra),
            .right_h     (rh),
            .valid       (c_valid[i]),
            .dl          (c_dl[i]),
            .at          (c_at[i]),
            .h           (c_h[i]),
            .move_out    (c_move[i+1]),
            .rem_out     (c_rem[i+1]),
            .valid_next  (c_vnext[i]),
            .dl_next     (c_dnext[i])
        );
    end

    // Lowest free handle
    always_comb
    begin
        free_h = '0;
        for (int i = TIMER_SLOTS - 1; i >= 0; i--)
        begin
            if (!busy_reg[i])
            begin
                free_h = HW'(i);
            end
        end
    end

    assign full  = c_valid[TIMER_SLOTS-1];
    assign found = c_rem[TIMER_SLOTS];
    assign due0  = c_valid[0] && (c_dl[0] <= now_reg);
    assign due1  = c_valid[1] && (c_dl[1] <= now_reg);

    assign out_free = !out_valid_reg || out_ready;
    assign load     = (state_reg == ST_EXEC) && out_free;

    // Execute control
    always_comb
    begin
        ctl        = '0;
        pop_en     = 1'b0;
        set_en     = 1'b0;
        clr_en     = 1'b0;
        clr_key    = key;
        r_handle   = '0;
        r_acc      = 1'b0;
        r_fired    = 1'b0;
        r_at       = '0;
        r_last     = 1'b1;
        cnt_next   = cnt_reg;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                cnt_next = '0;
                if (in_beat)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (load)
                begin
                    unique case (func_reg)
                        FUNC_ADD:
                        begin
                            if (!full)
                            begin
                                ctl.ins_en = 1'b1;
                                set_en     = 1'b1;
                                r_handle   = HANDLE_BITS'(HCW'(free_h));
                                r_acc      = 1'b1;
                            end
                        end
                        FUNC_DEL:
                        begin
                            ctl.rem_en = 1'b1;
                            clr_en     = found;
                            r_handle   = hin_reg;
                            r_acc      = found;
                        end
                        FUNC_TICK:
                        begin
                            if (due0)
                            begin
                                pop_en   = 1'b1;
                                clr_en   = 1'b1;
                                clr_key  = HCW'(c_h[0]);
                                r_handle = HANDLE_BITS'(HCW'(c_h[0]));
                                r_fired  = 1'b1;
                                r_at     = c_at[0];
                                r_last   = !(due1 && (cnt_reg != CNT_BITS'(MAX_RESULTS - 1)));
                                cnt_next = cnt_reg + 1'b1;
                            end
                        end
                        default:
                        begin
                            r_handle = '0;
                        end
                    endcase
                    if (r_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Handle map update
    always_comb
    begin
        busy_next = busy_reg;
        for (int j = 0; j < TIMER_SLOTS; j++)
        begin
            if (set_en && (free_h == HW'(j)))
            begin
                busy_next[j] = 1'b1;
            end
            if (clr_en && (clr_key == HCW'(j)))
            begin
                busy_next[j] = 1'b0;
            end
        end
    end

    // Wait to the front deadline after this step
    assign diff   = (c_dnext[0] > now_reg) ? (c_dnext[0] - now_reg) : '0;
    assign diff_w = WIDE_BITS'(diff);
    always_comb
    begin
        if (!c_vnext[0] || (diff_w[WIDE_BITS-1:WAIT_BITS] != '0))
        begin
            wait_calc = '1;
        end
        else
        begin
            wait_calc = diff_w[WAIT_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            busy_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            busy_reg  <= busy_next;
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            handle_out_reg     <= r_handle;
            accepted_reg       <= r_acc;
            fired_reg          <= r_fired;
            fired_add_time_reg <= NOW_BITS'(WIDE_BITS'(r_at));
            wait_time_reg      <= wait_calc;
            queue_empty_reg    <= !c_vnext[0];
            last_reg           <= r_last;
        end
    end

    assign out_valid      = out_valid_reg;
    assign handle_out     = handle_out_reg;
    assign accepted       = accepted_reg;
    assign fired          = fired_reg;
    assign fired_add_time = fired_add_time_reg;
    assign wait_time      = wait_time_reg;
    assign queue_empty    = queue_empty_reg;
    assign last           = last_reg;

endmodule

FILE: hw/rtl/dotq_checker.sv
// Port-level assertions for the timer queue, bound to the top level.
module dotq_checker
    import dotq_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   in_ready,
    input logic                   out_valid,
    input logic                   out_ready,
    input logic                   accepted,
    input logic                   fired,
    input logic [NOW_BITS-1:0]    fired_add_time,
    input logic [WAIT_BITS-1:0]   wait_time,
    input logic                   queue_empty,
    input logic                   last
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result beat dropped while stalled");

    a_fired_not_acc: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && fired |-> !accepted)
        else $error("fired result marked accepted");

    a_empty_wait: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && queue_empty |-> wait_time == '1)
        else $error("empty queue with finite wait");

    a_no_fire_time: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !fired |-> fired_add_time == '0)
        else $error("add time on a result that did not fire");

    a_busy_mid_burst: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> !in_ready)
        else $error("input taken during a tick burst");

endmodule

bind deadline_ordered_timer_queue dotq_checker u_dotq_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ready       (in_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .accepted       (accepted),
    .fired          (fired),
    .fired_add_time (fired_add_time),
    .wait_time      (wait_time),
    .queue_empty    (queue_empty),
    .last           (last)
);
